FILE: sv/atu2d_pkg.sv
// Package: shared types, opcodes and matrix classification for the 2-D affine unit.
package atu2d_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_POST  = 3'd1;
    localparam logic [2:0] OP_PRE   = 3'd2;
    localparam logic [2:0] OP_INV   = 3'd3;
    localparam logic [2:0] OP_POINT = 3'd4;

    localparam logic [2:0] K_TRANSLATE = 3'b001;
    localparam logic [2:0] K_SCALE     = 3'b010;
    localparam logic [2:0] K_SHEAR     = 3'b100;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] in_xx_or_px;
        logic signed [31:0] in_yx_or_py;
        logic signed [31:0] in_xy;
        logic signed [31:0] in_yy;
        logic signed [31:0] in_xt;
        logic signed [31:0] in_yt;
        logic               batch_last;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] determinant;
        logic               singular;
        logic [2:0]         kind;
        logic               last_out;
    } rsp_t;

    typedef struct packed {
        logic [31:0] xx;
        logic [31:0] yx;
        logic [31:0] xy;
        logic [31:0] yy;
        logic [31:0] xt;
        logic [31:0] yt;
    } amat_t;

    function automatic logic [2:0] classify(amat_t m, logic [31:0] one);
        logic [2:0] k;
        k = '0;
        if (m.xt != '0 || m.yt != '0) k = k | K_TRANSLATE;
        if (m.xx != '0 || m.yy != '0) k = k | K_SCALE;
        if (m.xy != '0 || m.yx != '0) k = k | K_SHEAR;
        if (k == K_SCALE && m.xx == one && m.yy == one) k = '0;
        return k;
    endfunction

endpackage

FILE: sv/affine_transform_unit_2d.sv
// Top level: 2-D affine transform unit with one shared multiplier and a bit-serial divider.
//
//  channel | signals                        | direction | moves
//  --------+--------------------------------+-----------+-------------------------
//  req     | req_valid, req_stall, req      | in        | one request (req_t)
//  rsp     | rsp_valid, rsp_stall, rsp      | out       | one result (rsp_t)
//
// Work per request is set by the single 32x32 multiplier (one product per cycle). A
//   multiply copies the operand when the current kind is 0 and is skipped when the
//   operand's kind is 0; invert runs the divider (one quotient bit per cycle) unless
//   singular. A held result register delays the return to idle.
// Reset: matrix is identity, kind 0, determinant one; no clearing pass.
// req_stall is high while a request is in work; rsp_stall holds the result register,
// and the next request is still taken while a result waits.
module affine_transform_unit_2d
    import atu2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
    localparam int QW = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] CNT_TOP = CW'(QW - 1);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DIV, S_FIN, S_OUT} state_t;
    typedef enum logic [1:0] {PG_PT, PG_MUL, PG_DET, PG_INV} prog_t;

    state_t             state_reg;
    prog_t              prog_reg;
    logic [3:0]         step_reg;
    logic               mv_reg;
    logic [3:0]         midx_reg;
    logic signed [63:0] mul_reg;
    logic [31:0]        pr_reg [12];
    amat_t              c_reg;
    logic [2:0]         kind_reg;
    logic [31:0]        det_reg;
    req_t               g_reg;
    logic               post_reg;
    logic               inv_pend_reg;
    logic               sing_reg;
    logic [31:0]        ox_reg;
    logic [31:0]        oy_reg;
    logic [32:0]        rem_reg;
    logic [QW-1:0]      q_reg;
    logic [CW-1:0]      cnt_reg;
    logic [31:0]        dv_reg;
    logic               dneg_reg;
    logic [31:0]        idet_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    amat_t       gm, am, bm, rm, im, rq;
    logic [2:0]  gk;
    logic [31:0] opa, opb, fm, t1, t2, det_val, ox_val, oy_val;
    logic [3:0]  n_prods;
    logic [32:0] rem_sh, rem_new;
    logic        ge;
    logic [QW-1:0] q_fin;
    logic [63:0] qx, qs;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        gm = '{xx: req.in_xx_or_px, yx: req.in_yx_or_py, xy: req.in_xy,
               yy: req.in_yy, xt: req.in_xt, yt: req.in_yt};
        gk = classify(gm, ONE);
        rq = '{xx: g_reg.in_xx_or_px, yx: g_reg.in_yx_or_py, xy: g_reg.in_xy,
               yy: g_reg.in_yy, xt: g_reg.in_xt, yt: g_reg.in_yt};
        am = post_reg ? c_reg : rq;
        bm = post_reg ? rq : c_reg;
        fm = mul_reg[FRAC_BITS+31:FRAC_BITS];
        t1 = pr_reg[0] - pr_reg[1];
        t2 = pr_reg[2] - pr_reg[3];
        det_val = pr_reg[0] - pr_reg[1];
    end

    always_comb
    begin
        opa = '0;
        opb = '0;
        n_prods = 4'd0;
        unique case (prog_reg)
            PG_PT:
            begin
                n_prods = 4'd4;
                case (step_reg)
                    4'd0:    begin opa = c_reg.xx; opb = g_reg.in_xx_or_px; end
                    4'd1:    begin opa = c_reg.xy; opb = g_reg.in_yx_or_py; end
                    4'd2:    begin opa = c_reg.yx; opb = g_reg.in_xx_or_px; end
                    4'd3:    begin opa = c_reg.yy; opb = g_reg.in_yx_or_py; end
                    default: ;
                endcase
            end
            PG_MUL:
            begin
                n_prods = 4'd12;
                case (step_reg)
                    4'd0:    begin opa = am.xx; opb = bm.xx; end
                    4'd1:    begin opa = am.xy; opb = bm.yx; end
                    4'd2:    begin opa = am.xx; opb = bm.xy; end
                    4'd3:    begin opa = am.xy; opb = bm.yy; end
                    4'd4:    begin opa = am.xx; opb = bm.xt; end
                    4'd5:    begin opa = am.xy; opb = bm.yt; end
                    4'd6:    begin opa = am.yx; opb = bm.xx; end
                    4'd7:    begin opa = am.yy; opb = bm.yx; end
                    4'd8:    begin opa = am.yx; opb = bm.xy; end
                    4'd9:    begin opa = am.yy; opb = bm.yy; end
                    4'd10:   begin opa = am.yx; opb = bm.xt; end
                    4'd11:   begin opa = am.yy; opb = bm.yt; end
                    default: ;
                endcase
            end
            PG_DET:
            begin
                n_prods = 4'd2;
                case (step_reg)
                    4'd0:    begin opa = c_reg.xx; opb = c_reg.yy; end
                    4'd1:    begin opa = c_reg.xy; opb = c_reg.yx; end
                    default: ;
                endcase
            end
            PG_INV:
            begin
                n_prods = 4'd10;
                case (step_reg)
                    4'd0:    begin opa = c_reg.xy; opb = c_reg.yt; end
                    4'd1:    begin opa = c_reg.yy; opb = c_reg.xt; end
                    4'd2:    begin opa = c_reg.yx; opb = c_reg.xt; end
                    4'd3:    begin opa = c_reg.xx; opb = c_reg.yt; end
                    4'd4:    begin opa = c_reg.yy; opb = idet_reg; end
                    4'd5:    begin opa = c_reg.yx; opb = idet_reg; end
                    4'd6:    begin opa = c_reg.xy; opb = idet_reg; end
                    4'd7:    begin opa = c_reg.xx; opb = idet_reg; end
                    4'd8:    begin opa = t1;       opb = idet_reg; end
                    4'd9:    begin opa = t2;       opb = idet_reg; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rm.xx = pr_reg[0] + pr_reg[1];
        rm.xy = pr_reg[2] + pr_reg[3];
        rm.xt = pr_reg[4] + pr_reg[5] + am.xt;
        rm.yx = pr_reg[6] + pr_reg[7];
        rm.yy = pr_reg[8] + pr_reg[9];
        rm.yt = pr_reg[10] + pr_reg[11] + am.yt;
        im.xx = pr_reg[4];
        im.yx = 32'd0 - pr_reg[5];
        im.xy = 32'd0 - pr_reg[6];
        im.yy = pr_reg[7];
        im.xt = pr_reg[8];
        im.yt = pr_reg[9];
        ox_val = ((kind_reg[1] | kind_reg[2]) ? pr_reg[0] : g_reg.in_xx_or_px)
               + (kind_reg[2] ? pr_reg[1] : 32'd0)
               + ((kind_reg[0] | kind_reg[2]) ? c_reg.xt : 32'd0);
        oy_val = ((kind_reg[1] | kind_reg[2]) ? pr_reg[3] : g_reg.in_yx_or_py)
               + (kind_reg[2] ? pr_reg[2] : 32'd0)
               + ((kind_reg[0] | kind_reg[2]) ? c_reg.yt : 32'd0);
    end

    // restoring divider: 2^(2*FRAC_BITS) / |det|
    always_comb
    begin
        rem_sh  = {rem_reg[31:0], cnt_reg == CNT_TOP};
        ge      = (rem_sh >= {1'b0, dv_reg});
        rem_new = ge ? (rem_sh - {1'b0, dv_reg}) : rem_sh;
        q_fin   = {q_reg[QW-2:0], ge};
        qx      = 64'(q_fin);
        qs      = dneg_reg ? (64'd0 - qx) : qx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prog_reg      <= PG_DET;
            step_reg      <= '0;
            mv_reg        <= 1'b0;
            c_reg         <= '{xx: ONE, yx: 32'd0, xy: 32'd0, yy: ONE, xt: 32'd0, yt: 32'd0};
            kind_reg      <= '0;
            det_reg       <= ONE;
            inv_pend_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            mv_reg <= (state_reg == S_RUN) && (step_reg < n_prods);
            if (mv_reg)
            begin
                pr_reg[midx_reg] <= fm;
            end
            if (state_reg == S_OUT && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        g_reg    <= req;
                        post_reg <= (req.opcode == OP_POST);
                        sing_reg <= 1'b0;
                        ox_reg   <= '0;
                        oy_reg   <= '0;
                        step_reg <= '0;
                        unique case (req.opcode) inside
                            OP_LOAD:
                            begin
                                c_reg     <= gm;
                                kind_reg  <= gk;
                                prog_reg  <= PG_DET;
                                state_reg <= S_RUN;
                            end
                            OP_POST, OP_PRE:
                            begin
                                if (kind_reg == '0)
                                begin
                                    c_reg     <= gm;
                                    kind_reg  <= gk;
                                    prog_reg  <= PG_DET;
                                    state_reg <= S_RUN;
                                end
                                else if (gk == '0)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    kind_reg  <= kind_reg | gk;
                                    prog_reg  <= PG_MUL;
                                    state_reg <= S_RUN;
                                end
                            end
                            OP_INV:
                            begin
                                inv_pend_reg <= 1'b1;
                                prog_reg     <= PG_DET;
                                state_reg    <= S_RUN;
                            end
                            OP_POINT:
                            begin
                                prog_reg  <= PG_PT;
                                state_reg <= S_RUN;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    if (step_reg < n_prods)
                    begin
                        mul_reg  <= $signed(opa) * $signed(opb);
                        midx_reg <= step_reg;
                        step_reg <= step_reg + 4'd1;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_new;
                    q_reg   <= q_fin;
                    if (cnt_reg == '0)
                    begin
                        idet_reg  <= qs[31:0];
                        prog_reg  <= PG_INV;
                        step_reg  <= '0;
                        state_reg <= S_RUN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                S_FIN:
                begin
                    step_reg <= '0;
                    unique case (prog_reg)
                        PG_PT:
                        begin
                            ox_reg    <= ox_val;
                            oy_reg    <= oy_val;
                            state_reg <= S_OUT;
                        end
                        PG_MUL:
                        begin
                            c_reg     <= rm;
                            prog_reg  <= PG_DET;
                            state_reg <= S_RUN;
                        end
                        PG_INV:
                        begin
                            c_reg     <= im;
                            kind_reg  <= classify(im, ONE);
                            prog_reg  <= PG_DET;
                            state_reg <= S_RUN;
                        end
                        PG_DET:
                        begin
                            if (!inv_pend_reg)
                            begin
                                det_reg   <= det_val;
                                state_reg <= S_OUT;
                            end
                            else if (det_val == '0)
                            begin
                                inv_pend_reg <= 1'b0;
                                c_reg <= '{xx: ONE, yx: 32'd0, xy: 32'd0, yy: ONE,
                                           xt: 32'd0, yt: 32'd0};
                                kind_reg  <= '0;
                                det_reg   <= ONE;
                                sing_reg  <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                inv_pend_reg <= 1'b0;
                                dneg_reg  <= det_val[31];
                                dv_reg    <= det_val[31] ? (32'd0 - det_val) : det_val;
                                rem_reg   <= '0;
                                q_reg     <= '0;
                                cnt_reg   <= CNT_TOP;
                                state_reg <= S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
                S_OUT:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg.out_x       <= ox_reg;
                        rsp_reg.out_y       <= oy_reg;
                        rsp_reg.determinant <= det_reg;
                        rsp_reg.singular    <= sing_reg;
                        rsp_reg.kind        <= kind_reg;
                        rsp_reg.last_out    <= g_reg.batch_last;
                        state_reg           <= S_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted but unit not busy");

    a_singular_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.singular) |-> (rsp.kind == '0 && rsp.determinant == ONE))
        else $error("singular result without identity matrix");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (step_reg <= n_prods))
        else $error("product step out of range");

endmodule
